@@ rtl/spq_pkg.sv @@
`timescale 1ns / 1ps
// Shared package of the strict priority four class queue.
// Holds command and status codes, field widths and the statistics update type.
package spq_pkg;

  localparam int CLASS_COUNT = 4;
  localparam int CLASS_BITS = 2;
  localparam int TIME_BITS = 11;
  localparam int WAIT_BITS = 12;
  localparam int COUNT_BITS = 16;
  localparam logic [TIME_BITS-1:0] MIN_PER_HOUR = 11'd60;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = 16'hFFFF;

  localparam logic [1:0] CMD_REGISTER = 2'd0;
  localparam logic [1:0] CMD_SERVE = 2'd1;
  localparam logic [1:0] CMD_REPORT = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [2:0] STATUS_REGISTERED = 3'd0;
  localparam logic [2:0] STATUS_SERVED = 3'd1;
  localparam logic [2:0] STATUS_EMPTY = 3'd2;
  localparam logic [2:0] STATUS_DROPPED = 3'd3;
  localparam logic [2:0] STATUS_REPORT = 3'd4;

  typedef struct packed {
    logic serve;
    logic [CLASS_BITS-1:0] cls;
    logic signed [WAIT_BITS-1:0] wait_min;
  } spq_upd_t;

endpackage

@@ rtl/spq_ram.sv @@
`timescale 1ns / 1ps
// Generic single write port RAM with one registered read port.
// Depends on nothing.
module spq_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/spq_stats.sv @@
`timescale 1ns / 1ps
// Service statistics: per class and overall served counts, peak occupancy
// and greatest wait. Depends on spq_pkg.
module spq_stats
  import spq_pkg::*;
#(
  parameter int TOT_W = 7
) (
  input  logic                          clk,
  input  logic                          rst,
  input  spq_upd_t                      upd,
  input  logic                          peak_chk,
  input  logic [TOT_W-1:0]              total_after,
  output logic [COUNT_BITS-1:0]         served_next [CLASS_COUNT],
  output logic [COUNT_BITS-1:0]         served_all_next,
  output logic [TOT_W-1:0]              peak_next,
  output logic signed [WAIT_BITS-1:0]   worst_next
);

  logic [COUNT_BITS-1:0] served [CLASS_COUNT];
  logic [COUNT_BITS-1:0] served_all;
  logic [TOT_W-1:0] peak;
  logic signed [WAIT_BITS-1:0] worst;
  logic any_served;

  always_comb begin
    for (int c = 0; c < CLASS_COUNT; c++) begin
      if (upd.serve && upd.cls == CLASS_BITS'(c) && served[c] != COUNT_MAX) begin
        served_next[c] = served[c] + 1'b1;
      end else begin
        served_next[c] = served[c];
      end
    end
    if (upd.serve && served_all != COUNT_MAX) begin
      served_all_next = served_all + 1'b1;
    end else begin
      served_all_next = served_all;
    end
    if (peak_chk && total_after > peak) begin
      peak_next = total_after;
    end else begin
      peak_next = peak;
    end
    if (upd.serve && (!any_served || upd.wait_min > worst)) begin
      worst_next = upd.wait_min;
    end else begin
      worst_next = worst;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CLASS_COUNT; c++) begin
        served[c] <= '0;
      end
      served_all <= '0;
      peak <= '0;
      worst <= '0;
      any_served <= 1'b0;
    end else begin
      served <= served_next;
      served_all <= served_all_next;
      peak <= peak_next;
      worst <= worst_next;
      if (upd.serve) begin
        any_served <= 1'b1;
      end
    end
  end

endmodule

@@ rtl/strict_priority_four_class_queue_top.sv @@
`timescale 1ns / 1ps
// Strict priority scheduler over four ticket queues kept in one entry RAM.
// A register, serve or report request is first accepted, which for a serve
// also starts the RAM read of the head entry, and then updates the queue and
// loads the result register, waiting while the result register is stalled.
// No new request is accepted before the result register has been loaded.
// Synchronous reset empties all queues and clears all statistics.
module strict_priority_four_class_queue_top
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int TICKET_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  cmd,
  input  logic [15:0]                 ticket,
  input  logic [1:0]                  class_code,
  input  logic [4:0]                  hour,
  input  logic [5:0]                  minute,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  status,
  output logic [15:0]                 served_ticket,
  output logic [1:0]                  served_class,
  output logic signed [11:0]          wait_minutes,
  output logic [4:0]                  queue_length,
  output logic [6:0]                  waiting_total,
  output logic [15:0]                 class_served_count,
  output logic [15:0]                 served_total,
  output logic [6:0]                  peak_occupancy,
  output logic signed [11:0]          max_wait
);

  localparam int LEN_W = $clog2(QUEUE_DEPTH + 1);
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int TOT_W = $clog2(CLASS_COUNT * QUEUE_DEPTH + 1);
  localparam int RAM_DEPTH = CLASS_COUNT * QUEUE_DEPTH;
  localparam int ADDR_W = $clog2(RAM_DEPTH);
  localparam int ENTRY_W = TICKET_BITS + TIME_BITS;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  logic [1:0] cmd_q;
  logic [TICKET_BITS-1:0] ticket_q;
  logic [CLASS_BITS-1:0] cls_q;
  logic [4:0] hour_q;
  logic [5:0] minute_q;
  logic [CLASS_BITS-1:0] srv_cls_q;
  logic srv_hit_q;

  logic [PTR_W-1:0] head [CLASS_COUNT];
  logic [PTR_W-1:0] tail [CLASS_COUNT];
  logic [LEN_W-1:0] len [CLASS_COUNT];
  logic [LEN_W-1:0] len_next [CLASS_COUNT];
  logic [TOT_W-1:0] total;
  logic [TOT_W-1:0] total_next;

  logic in_accept;
  logic out_free;
  logic exec_fire;
  logic [CLASS_BITS-1:0] sel_cls;
  logic sel_hit;
  logic full;
  logic do_reg;
  logic do_srv;

  logic ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  logic [TIME_BITS-1:0] call_time;
  logic [TIME_BITS-1:0] arrive_time;
  logic signed [WAIT_BITS-1:0] wait_calc;

  spq_upd_t upd;
  logic [COUNT_BITS-1:0] served_next [CLASS_COUNT];
  logic [COUNT_BITS-1:0] served_all_next;
  logic [TOT_W-1:0] peak_next;
  logic signed [WAIT_BITS-1:0] worst_next;

  assign in_stall = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign exec_fire = (state == S_EXEC) && out_free;

  always_comb begin
    sel_cls = '0;
    sel_hit = 1'b0;
    for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
      if (len[c] != '0) begin
        sel_cls = CLASS_BITS'(c);
        sel_hit = 1'b1;
      end
    end
  end

  assign ram_re = in_accept && cmd == CMD_SERVE;
  assign ram_raddr = ADDR_W'(sel_cls) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head[sel_cls]);

  assign full = (len[cls_q] == LEN_W'(QUEUE_DEPTH));
  assign do_reg = (cmd_q == CMD_REGISTER) && !full;
  assign do_srv = (cmd_q == CMD_SERVE) && srv_hit_q;

  assign ram_we = exec_fire && do_reg;
  assign ram_waddr = ADDR_W'(cls_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail[cls_q]);
  assign ram_wdata = {ticket_q, hour_q, minute_q};

  assign call_time = TIME_BITS'(hour_q) * MIN_PER_HOUR + TIME_BITS'(minute_q);
  assign arrive_time = TIME_BITS'(ram_rdata[10:6]) * MIN_PER_HOUR
                     + TIME_BITS'(ram_rdata[5:0]);
  assign wait_calc = $signed({1'b0, call_time}) - $signed({1'b0, arrive_time});

  always_comb begin
    for (int c = 0; c < CLASS_COUNT; c++) begin
      len_next[c] = len[c];
      if (do_reg && cls_q == CLASS_BITS'(c)) begin
        len_next[c] = len[c] + 1'b1;
      end
      if (do_srv && srv_cls_q == CLASS_BITS'(c)) begin
        len_next[c] = len[c] - 1'b1;
      end
    end
    total_next = total;
    if (do_reg) begin
      total_next = total + 1'b1;
    end else if (do_srv) begin
      total_next = total - 1'b1;
    end
  end

  assign upd.serve = exec_fire && do_srv;
  assign upd.cls = srv_cls_q;
  assign upd.wait_min = wait_calc;

  spq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(RAM_DEPTH)
  ) u_entry_ram (
    .clk(clk),
    .we(ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re(ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  spq_stats #(
    .TOT_W(TOT_W)
  ) u_stats (
    .clk(clk),
    .rst(rst),
    .upd(upd),
    .peak_chk(exec_fire && cmd_q == CMD_REGISTER),
    .total_after(total_next),
    .served_next(served_next),
    .served_all_next(served_all_next),
    .peak_next(peak_next),
    .worst_next(worst_next)
  );

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_q <= cmd;
      ticket_q <= TICKET_BITS'(ticket);
      cls_q <= class_code;
      hour_q <= hour;
      minute_q <= minute;
      srv_cls_q <= sel_cls;
      srv_hit_q <= sel_hit;
    end
    if (exec_fire) begin
      if (cmd_q == CMD_REGISTER) begin
        status <= full ? STATUS_DROPPED : STATUS_REGISTERED;
      end else if (cmd_q == CMD_SERVE) begin
        status <= srv_hit_q ? STATUS_SERVED : STATUS_EMPTY;
      end else begin
        status <= STATUS_REPORT;
      end
      served_ticket <= do_srv ? 16'(ram_rdata[ENTRY_W-1 -: TICKET_BITS]) : '0;
      served_class <= do_srv ? srv_cls_q : '0;
      wait_minutes <= do_srv ? wait_calc : '0;
      queue_length <= 5'(len_next[cls_q]);
      waiting_total <= 7'(total_next);
      class_served_count <= served_next[cls_q];
      served_total <= served_all_next;
      peak_occupancy <= 7'(peak_next);
      max_wait <= worst_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      total <= '0;
      for (int c = 0; c < CLASS_COUNT; c++) begin
        head[c] <= '0;
        tail[c] <= '0;
        len[c] <= '0;
      end
    end else begin
      if (exec_fire) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept && cmd != CMD_UNUSED) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_fire) begin
            state <= S_IDLE;
            len <= len_next;
            total <= total_next;
            for (int c = 0; c < CLASS_COUNT; c++) begin
              if (do_reg && cls_q == CLASS_BITS'(c)) begin
                tail[c] <= (tail[c] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail[c] + 1'b1;
              end
              if (do_srv && srv_cls_q == CLASS_BITS'(c)) begin
                head[c] <= (head[c] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head[c] + 1'b1;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
